// ===== rtl/ncm_pkg.sv =====
package ncm_pkg;

  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_WRITE     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_THRESHOLD = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP       = 2'd3;

  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_CLUSTER_COUNT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FEATURE_COUNT = 1'd1;
  localparam int CFG_DATA_W = 5;

  localparam int DIST_W = 18;
  localparam int RES_KIND_QUERY     = 0;
  localparam int RES_KIND_THRESHOLD = 1;

  // controller -> datapath commands
  typedef struct packed {
    logic clear_step; // zero one centroid entry after reset
    logic start;      // latch input transaction, begin element
    logic acc_step;   // process one cluster (read data valid)
    logic row_finish; // accumulation done; starts the result phase if one is due
    logic sqrt_start;
    logic sqrt_step;
    logic out_load;
  } ncm_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic clear_done;
    logic last_cluster;
    logic need_result;
    logic sqrt_done;
  } ncm_sts_t;

endpackage

// ===== rtl/ncm_ram.sv =====
module ncm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/ncm_ctrl.sv =====
module ncm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_busy,
  output ncm_pkg::ncm_cmd_t cmd,
  input  ncm_pkg::ncm_sts_t sts
);
  import ncm_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_READ  = 7'b0000100,
    ST_ACC   = 7'b0001000,
    ST_SQRT  = 7'b0010000,
    ST_OUT   = 7'b0100000,
    ST_WAIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_ACC;
      ST_ACC: begin
        cmd.acc_step = 1'b1;
        if (sts.last_cluster) begin
          cmd.row_finish = 1'b1;
          if (sts.need_result) begin
            state_nxt = ST_SQRT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_done) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    cmd.sqrt_start = cmd.row_finish && sts.need_result;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

// ===== rtl/ncm_dp.sv =====
module ncm_dp #(
  parameter int MAX_CLUSTERS = 16,
  parameter int MAX_FEATURES = 16,
  parameter int FEATURE_BITS = 16,
  parameter int CI_W = 4,
  parameter int CNT_W = 5
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [CNT_W-1:0]         cluster_count,
  input  logic [CNT_W-1:0]         feature_count,
  input  logic [1:0]               in_cmd,
  input  logic [CI_W-1:0]          in_cluster_index,
  input  logic signed [FEATURE_BITS-1:0] in_feature_value,
  input  logic                     in_last_sample,
  input  ncm_pkg::ncm_cmd_t        cmd,
  output ncm_pkg::ncm_sts_t        sts,
  output logic                     res_kind,
  output logic                     res_success,
  output logic [CI_W-1:0]          res_index,
  output logic [ncm_pkg::DIST_W-1:0] res_dist
);
  import ncm_pkg::*;

  localparam int CL_W  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int FT_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CC_W  = $clog2(MAX_CLUSTERS + 1);
  localparam int ADR_W = $clog2(MAX_CLUSTERS * MAX_FEATURES) > 0 ?
                         $clog2(MAX_CLUSTERS * MAX_FEATURES) : 1;
  localparam int DIF_W = FEATURE_BITS + 1;
  localparam int SQ_W  = 2 * DIF_W;
  localparam int ACC_W = SQ_W + FT_W + 1;
  localparam int RT_W  = (ACC_W + 1) / 2;
  localparam int SQRT_STEPS = RT_W;

  // effective configuration
  logic [CC_W-1:0] cc_eff;
  logic [FT_W:0]   fc_eff;
  always_comb begin
    if (32'(cluster_count) > MAX_CLUSTERS) cc_eff = CC_W'(MAX_CLUSTERS);
    else cc_eff = CC_W'(cluster_count);
    if (cluster_count == '0) cc_eff = '0;
    if (feature_count == '0) fc_eff = (FT_W+1)'(1);
    else if (32'(feature_count) > MAX_FEATURES) fc_eff = (FT_W+1)'(MAX_FEATURES);
    else fc_eff = (FT_W+1)'(feature_count);
  end

  logic [1:0]              cmd_r;
  logic signed [FEATURE_BITS-1:0] x_r;
  logic                    last_r;
  logic [FT_W-1:0]         pos_r;
  logic [FT_W-1:0]         epos_r;    // position of the element in flight
  logic                    row_end_r;
  logic [CL_W-1:0]         cl_r;      // cluster being read
  logic                    valid_r;   // threshold target in use
  logic                    found_r;
  logic [CL_W-1:0]         best_r;
  logic [ACC_W-1:0]        best_sum_r;
  logic [ACC_W-1:0]        largest_r;
  logic [ACC_W-1:0]        acc_r [MAX_CLUSTERS];
  logic [ADR_W:0]          clr_cnt_r;
  logic                    clr_done;

  // centroid memory
  logic                    wr_en;
  logic [ADR_W-1:0]        wr_addr, rd_addr;
  logic [FEATURE_BITS-1:0] wr_data;
  logic [FEATURE_BITS-1:0] rd_data;
  logic [CL_W-1:0]         rd_cl;

  ncm_ram #(.WIDTH(FEATURE_BITS), .DEPTH(MAX_CLUSTERS * MAX_FEATURES)) u_cent (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
    .raddr(rd_addr), .rdata(rd_data)
  );

  logic [FT_W:0] pos_start;
  logic          in_cc;
  always_comb begin
    clr_done = 32'(clr_cnt_r) >= MAX_CLUSTERS * MAX_FEATURES;
    pos_start = {1'b0, pos_r};
    in_cc = (CC_W+1)'(in_cluster_index) < (CC_W+1)'(cc_eff);
    if (cmd.clear_step) begin
      wr_en = !clr_done;
      wr_addr = ADR_W'(clr_cnt_r);
      wr_data = '0;
    end else begin
      wr_en = cmd.start && (in_cmd == CMD_WRITE) && in_cc;
      wr_addr = ADR_W'(CL_W'(in_cluster_index) * MAX_FEATURES + 32'(pos_r));
      wr_data = in_feature_value;
    end
    if (cmd.start) begin
      rd_cl = (in_cmd == CMD_THRESHOLD) ? CL_W'(in_cluster_index) : '0;
      rd_addr = ADR_W'(32'(rd_cl) * MAX_FEATURES + 32'(pos_r));
    end else begin
      rd_cl = cmd.acc_step ? cl_r + CL_W'(1) : cl_r;
      rd_addr = ADR_W'(32'(rd_cl) * MAX_FEATURES + 32'(epos_r));
    end
  end

  // square of difference against current read data
  logic signed [DIF_W-1:0] diff;
  logic [DIF_W-1:0]        adiff;
  logic [SQ_W-1:0]         sq;
  logic [ACC_W-1:0]        sum_cur;
  always_comb begin
    diff = DIF_W'(x_r) - DIF_W'($signed(rd_data));
    adiff = diff[DIF_W-1] ? DIF_W'(-diff) : DIF_W'(diff);
    sq = SQ_W'(adiff) * SQ_W'(adiff);
    sum_cur = acc_r[cl_r] + ACC_W'(sq);
  end

  // integer square root, two bits per step
  logic [2*RT_W-1:0] sq_v_r;
  logic [RT_W-1:0]  sq_res_r;
  logic [$clog2(SQRT_STEPS+1)-1:0] sq_cnt_r;
  logic [RT_W+1:0]  rem_r, rem_try;
  logic [RT_W+1:0]  rem_sh;
  logic [RT_W+1:0]  trial;
  always_comb begin
    rem_sh = {rem_r[RT_W-1:0], sq_v_r[2*RT_W-1 -: 2]};
    trial  = {sq_res_r, 2'b01};
    rem_try = rem_sh - trial;
  end

  logic single_cl, last_q;
  always_comb begin
    last_q = (CC_W'(cl_r) + CC_W'(1) >= cc_eff) || (cc_eff == '0);
    single_cl = (cmd_r != CMD_QUERY);
    sts.clear_done = clr_done;
    sts.last_cluster = single_cl ? 1'b1 : last_q;
    sts.need_result = row_end_r &&
      ((cmd_r == CMD_QUERY) || (cmd_r == CMD_THRESHOLD && last_r));
    sts.sqrt_done = (sq_cnt_r == '0);
  end

  logic [ACC_W-1:0] sqrt_src;
  logic             q_upd;
  always_comb begin
    q_upd = (cmd_r == CMD_QUERY) && (CC_W'(cl_r) < cc_eff) &&
            (!found_r || sum_cur <= best_sum_r);
    if (cmd_r == CMD_QUERY) begin
      sqrt_src = q_upd ? sum_cur : best_sum_r;
    end else if (valid_r && row_end_r && sum_cur > largest_r) begin
      sqrt_src = sum_cur;
    end else begin
      sqrt_src = largest_r;
    end
  end

  logic row_end_in;
  assign row_end_in = (pos_start + (FT_W+1)'(1)) >= fc_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      largest_r <= '0;
      sq_cnt_r <= '0;
      clr_cnt_r <= '0;
      for (int i = 0; i < MAX_CLUSTERS; i++) acc_r[i] <= '0;
    end else begin
      if (cmd.clear_step && !clr_done) begin
        clr_cnt_r <= clr_cnt_r + (ADR_W+1)'(1);
      end
      if (cmd.start) begin
        cmd_r <= in_cmd;
        x_r <= in_feature_value;
        last_r <= in_last_sample;
        row_end_r <= row_end_in;
        valid_r <= in_cc;
        found_r <= 1'b0;
        best_r <= '0;
        best_sum_r <= '0;
        cl_r <= rd_cl;
        epos_r <= pos_r;
        if (in_cmd != CMD_NOP) begin
          pos_r <= row_end_in ? '0 : pos_r + FT_W'(1);
        end
      end
      if (cmd.acc_step) begin
        cl_r <= rd_cl;
        if (cmd_r == CMD_QUERY && CC_W'(cl_r) < cc_eff) begin
          acc_r[cl_r] <= row_end_r ? '0 : sum_cur;
          if (q_upd) begin
            found_r <= 1'b1;
            best_r <= cl_r;
            best_sum_r <= sum_cur;
          end
        end else if (cmd_r == CMD_THRESHOLD && valid_r) begin
          acc_r[cl_r] <= row_end_r ? '0 : sum_cur;
          if (row_end_r && sum_cur > largest_r && !last_r) largest_r <= sum_cur;
        end
      end
      if (cmd.sqrt_start) begin
        sq_v_r <= (2*RT_W)'(sqrt_src);
        sq_res_r <= '0;
        rem_r <= '0;
        sq_cnt_r <= $bits(sq_cnt_r)'(SQRT_STEPS);
        if (cmd_r == CMD_THRESHOLD) largest_r <= '0;
      end
      if (cmd.sqrt_step && sq_cnt_r != '0) begin
        sq_cnt_r <= sq_cnt_r - $bits(sq_cnt_r)'(1);
        sq_v_r <= sq_v_r << 2;
        if (!rem_try[RT_W+1]) begin
          rem_r <= rem_try;
          sq_res_r <= {sq_res_r[RT_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          sq_res_r <= {sq_res_r[RT_W-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    res_kind = (cmd_r == CMD_THRESHOLD);
    res_success = (cmd_r == CMD_QUERY) ? found_r : valid_r;
    res_index = (cmd_r == CMD_QUERY && found_r) ? CI_W'(best_r) : '0;
    res_dist = res_success ? DIST_W'(sq_res_r) : '0;
  end
endmodule

// ===== rtl/nearest_centroid_matcher.sv =====
// Nearest-centroid matcher. Each input transaction carries one feature element;
// write and threshold commands visit a single centroid, and a query visits
// every configured cluster (one step with an empty table) through the
// single multiplier, one centroid per cycle. At a row end that reports a result,
// a 20-step integer square root follows, then the output register is loaded;
// the load waits while the previous result is still held.
// After reset the centroid table is cleared with in_ready low.
// One transaction is in flight at a time. Program cluster_count and
// feature_count through the cfg port while idle.
module nearest_centroid_matcher #(
  parameter int MAX_CLUSTERS = 16,
  parameter int MAX_FEATURES = 16,
  parameter int FEATURE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ncm_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [ncm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_cmd,
  input  logic [3:0]                    in_cluster_index,
  input  logic signed [FEATURE_BITS-1:0] in_feature_value,
  input  logic                          in_last_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_result_kind,
  output logic                          out_success,
  output logic [3:0]                    out_best_index,
  output logic [ncm_pkg::DIST_W-1:0]    out_distance
);
  import ncm_pkg::*;

  logic [4:0] cluster_count_r, feature_count_r;
  ncm_cmd_t cmd;
  ncm_sts_t sts;
  logic r_kind, r_succ;
  logic [3:0] r_idx;
  logic [DIST_W-1:0] r_dist;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cluster_count_r <= '0;
      feature_count_r <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLUSTER_COUNT: cluster_count_r <= cfg_data;
        REG_FEATURE_COUNT: feature_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ncm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_busy(out_valid && !out_ready), .cmd(cmd), .sts(sts)
  );

  ncm_dp #(
    .MAX_CLUSTERS(MAX_CLUSTERS), .MAX_FEATURES(MAX_FEATURES),
    .FEATURE_BITS(FEATURE_BITS), .CI_W(4), .CNT_W(5)
  ) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cluster_count(cluster_count_r), .feature_count(feature_count_r),
    .in_cmd(in_cmd), .in_cluster_index(in_cluster_index),
    .in_feature_value(in_feature_value), .in_last_sample(in_last_sample),
    .cmd(cmd), .sts(sts),
    .res_kind(r_kind), .res_success(r_succ), .res_index(r_idx), .res_dist(r_dist)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_result_kind <= r_kind;
      out_success <= r_succ;
      out_best_index <= r_idx;
      out_distance <= r_dist;
    end
  end

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_success |-> out_distance == '0 && out_best_index == '0)
    else $error("failure result carries nonzero payload");

  a_thr_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind |-> out_best_index == '0)
    else $error("threshold result carries an index");

  a_busy_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> !in_ready)
    else $error("input taken while an element is in flight");
endmodule
